@@ sv/stack_with_min_query_assert.svh @@
// Assertion macros for the stack with minimum query.
// Included by the top level; the macros have empty bodies when SYNTHESIS is defined.
`ifndef STACK_WITH_MIN_QUERY_ASSERT_SVH
`define STACK_WITH_MIN_QUERY_ASSERT_SVH

`ifndef SYNTHESIS
`define SWMQ_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SWMQ_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`else
`define SWMQ_ASSERT(lbl, clk, rst_n, prop, msg)
`define SWMQ_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

@@ sv/swmq_pkg.sv @@
// Shared types and constants for the stack with minimum query.
// Depends on nothing; used by swmq_ctrl, swmq_dp, the top level and the testbench.
`default_nettype none

package swmq_pkg;

  localparam int unsigned DEPTH  = 128;
  localparam int unsigned WORD_W = 32;
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    FUNC_PUSH = 2'd0,
    FUNC_POP  = 2'd1,
    FUNC_MIN  = 2'd2,
    FUNC_NOP  = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_EMPTY    = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    SRC_ZERO  = 2'd0,
    SRC_RDATA = 2'd1,
    SRC_MIN   = 2'd2
  } res_src_e;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_POP  = 3'b010,
    S_MIN  = 3'b100
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic     push;
    logic     pop_start;
    logic     min_start;
    logic     min_step;
    logic     res_load;
    res_src_e res_src;
    status_e  res_status;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic empty;
    logic full;
    logic scan_last;
  } dp_stat_t;

endpackage

`default_nettype wire

@@ sv/swmq_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
`default_nettype none

module swmq_ram #(
  parameter  int unsigned Width = 32,
  parameter  int unsigned Depth = 128,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

@@ sv/swmq_ctrl.sv @@
// Controller state machine for the stack with minimum query.
// Depends on swmq_pkg; drives the datapath through dp_cmd_t.
`default_nettype none

module swmq_ctrl import swmq_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       start_i,
  input  wire logic [1:0] func_i,
  input  dp_stat_t        stat_i,
  output dp_cmd_t         cmd_o,
  output logic            busy_o
);

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.res_src    = SRC_ZERO;
    cmd_o.res_status = ST_OK;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.res_load = 1'b1;
          case (func_e'(func_i))
            FUNC_PUSH: begin
              if (stat_i.full) begin
                cmd_o.res_status = ST_OVERFLOW;
              end else begin
                cmd_o.push = 1'b1;
              end
            end
            FUNC_POP: begin
              if (stat_i.empty) begin
                cmd_o.res_status = ST_EMPTY;
              end else begin
                // read data returns next cycle; result loads then
                cmd_o.res_load  = 1'b0;
                cmd_o.pop_start = 1'b1;
                state_d         = S_POP;
              end
            end
            FUNC_MIN: begin
              if (stat_i.empty) begin
                cmd_o.res_status = ST_EMPTY;
              end else begin
                cmd_o.res_load  = 1'b0;
                cmd_o.min_start = 1'b1;
                state_d         = S_MIN;
              end
            end
            default: begin
              // unused selector: report ok, leave the stack alone
            end
          endcase
        end
      end
      S_POP: begin
        cmd_o.res_load = 1'b1;
        cmd_o.res_src  = SRC_RDATA;
        state_d        = S_IDLE;
      end
      S_MIN: begin
        cmd_o.min_step = 1'b1;
        if (stat_i.scan_last) begin
          cmd_o.res_load = 1'b1;
          cmd_o.res_src  = SRC_MIN;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

`default_nettype wire

@@ sv/swmq_dp.sv @@
// Datapath: word RAM, fill count, minimum scan and result registers.
// Depends on swmq_pkg and swmq_ram; commanded by swmq_ctrl.
`default_nettype none

module swmq_dp import swmq_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  dp_cmd_t                cmd_i,
  input  wire logic [WORD_W-1:0] push_value_i,
  output dp_stat_t               stat_o,
  output logic      [WORD_W-1:0] result_value_o,
  output logic      [1:0]        status_o,
  output logic                   done_o
);

  logic [CNT_W-1:0]  count_q, count_d;
  logic [CNT_W-1:0]  scan_idx_q, scan_idx_d;
  logic              first_q, first_d;
  logic [WORD_W-1:0] best_q, best_d;
  logic [WORD_W-1:0] result_q, result_d;
  logic [1:0]        status_q, status_d;
  logic              done_q;

  logic [CNT_W-1:0]  count_dec;
  logic              re;
  logic [ADDR_W-1:0] raddr;
  logic [WORD_W-1:0] rdata;
  logic [WORD_W-1:0] candidate;

  swmq_ram #(
    .Width (WORD_W),
    .Depth (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.push),
    .waddr_i (count_q[ADDR_W-1:0]),
    .wdata_i (push_value_i),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign count_dec = count_q - CNT_W'(1);

  assign stat_o.empty     = (count_q == '0);
  assign stat_o.full      = (count_q == CNT_W'(DEPTH));
  assign stat_o.scan_last = (scan_idx_q == count_q);

  // word arriving now is compared against the running minimum
  assign candidate = (first_q || ($signed(rdata) < $signed(best_q))) ? rdata : best_q;

  always_comb begin
    count_d    = count_q;
    scan_idx_d = scan_idx_q;
    first_d    = first_q;
    best_d     = best_q;
    re         = 1'b0;
    raddr      = scan_idx_q[ADDR_W-1:0];

    if (cmd_i.push) begin
      count_d = count_q + CNT_W'(1);
    end
    if (cmd_i.pop_start) begin
      count_d = count_dec;
      re      = 1'b1;
      raddr   = count_dec[ADDR_W-1:0];
    end
    if (cmd_i.min_start) begin
      re         = 1'b1;
      raddr      = '0;
      scan_idx_d = CNT_W'(1);
      first_d    = 1'b1;
    end
    if (cmd_i.min_step) begin
      best_d  = candidate;
      first_d = 1'b0;
      if (!stat_o.scan_last) begin
        re         = 1'b1;
        scan_idx_d = scan_idx_q + CNT_W'(1);
      end
    end

    case (cmd_i.res_src)
      SRC_RDATA: result_d = rdata;
      SRC_MIN:   result_d = candidate;
      default:   result_d = '0;
    endcase
    status_d = cmd_i.res_status;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      scan_idx_q <= '0;
      first_q    <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      count_q    <= count_d;
      scan_idx_q <= scan_idx_d;
      first_q    <= first_d;
      done_q     <= cmd_i.res_load;
    end
  end

  always_ff @(posedge clk_i) begin
    best_q <= best_d;
    if (cmd_i.res_load) begin
      result_q <= result_d;
      status_q <= status_d;
    end
  end

  assign result_value_o = result_q;
  assign status_o       = status_q;
  assign done_o         = done_q;

endmodule

`default_nettype wire

@@ sv/stack_with_min_query.sv @@
// Stack of signed 32-bit words with push, pop and minimum query; top level.
// Push, unused selector and refused requests: result in the cycle after acceptance, one per cycle.
// Pop: the RAM registers the read data, which loads into the result register in S_POP. Minimum
// query: the scan reads one RAM word per cycle, bottom up. busy is low in the result cycle.
// Results are strobed by done_o for one cycle; the receiver cannot stall.
// Reset empties the stack at once; RAM contents are not cleared and need no clearing pass.
`default_nettype none

`include "stack_with_min_query_assert.svh"

module stack_with_min_query import swmq_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [1:0]        func_i,
  input  wire logic [WORD_W-1:0] push_value_i,
  output logic                   done_o,
  output logic      [WORD_W-1:0] result_value_o,
  output logic      [1:0]        status_o
);

  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic     busy_int;

  swmq_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .func_i  (func_i),
    .stat_i  (stat),
    .cmd_o   (cmd),
    .busy_o  (busy_int)
  );

  swmq_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .push_value_i   (push_value_i),
    .stat_o         (stat),
    .result_value_o (result_value_o),
    .status_o       (status_o),
    .done_o         (done_o)
  );

  assign busy = busy_int;

  `SWMQ_ASSERT_IMPL(a_done_not_busy, clk_i, rst_ni, done_o, !busy, "result strobed while busy")
  `SWMQ_ASSERT(a_push_one_cycle, clk_i, rst_ni, (start && !busy && func_i == FUNC_PUSH) |=> done_o, "push result not next cycle")
  `SWMQ_ASSERT_IMPL(a_overflow_full, clk_i, rst_ni, done_o && status_o == ST_OVERFLOW, stat.full, "overflow reported while not full")
  `SWMQ_ASSERT_IMPL(a_err_zero, clk_i, rst_ni, done_o && status_o != ST_OK, result_value_o == '0, "non-zero value on error")

endmodule

`default_nettype wire

@@ dv/tb_stack_with_min_query.sv @@
// Self-checking testbench for stack_with_min_query: push, pop, minimum query and no-op requests.
// A directed table runs first, then random push, pop and scan episodes checked by a predictor.
// Depends on swmq_pkg and the stack_with_min_query top level.
module tb_stack_with_min_query;
  timeunit 1ns;
  timeprecision 1ps;

  import swmq_pkg::*;

  localparam int unsigned RANDOM_REQUESTS = 1625;

  typedef struct packed {
    logic [WORD_W-1:0] value;
    logic [1:0]        status;
  } outcome_t;

  typedef struct {
    func_e             op;
    logic [WORD_W-1:0] word;
    bit                typed;
    outcome_t          want;
  } stim_row_t;

  logic              clk_i        = 1'b0;
  logic              rst_ni       = 1'b0;
  logic              start        = 1'b0;
  logic [1:0]        func_i       = FUNC_NOP;
  logic [WORD_W-1:0] push_value_i = '0;
  logic              busy;
  logic              done_o;
  logic [WORD_W-1:0] result_value_o;
  logic [1:0]        status_o;

  // Shadow of the stack contents and fill level
  logic [WORD_W-1:0] model_words [DEPTH];
  int unsigned       model_fill = 0;

  outcome_t    pending_results[$];
  stim_row_t   stim_table[$];
  int unsigned fail_count = 0;
  int unsigned sent_count = 0;
  bit          steady_run = 1'b0;

  stack_with_min_query dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .func_i         (func_i),
    .push_value_i   (push_value_i),
    .done_o         (done_o),
    .result_value_o (result_value_o),
    .status_o       (status_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic outcome_t stack_model_step(logic [1:0] op, logic [WORD_W-1:0] word);
    outcome_t          r;
    logic [WORD_W-1:0] least;
    r.value  = '0;
    r.status = ST_OK;
    case (op)
      FUNC_PUSH: begin
        if (model_fill >= DEPTH) begin
          r.status = ST_OVERFLOW;
        end else begin
          model_words[model_fill] = word;
          model_fill++;
        end
      end
      FUNC_POP: begin
        if (model_fill == 0) begin
          r.status = ST_EMPTY;
        end else begin
          model_fill--;
          r.value = model_words[model_fill];
        end
      end
      FUNC_MIN: begin
        if (model_fill == 0) begin
          r.status = ST_EMPTY;
        end else begin
          least = model_words[0];
          for (int unsigned i = 1; i < model_fill; i++)
            if ($signed(model_words[i]) < $signed(least)) least = model_words[i];
          r.value = least;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Bias towards extremes and small values so that equal minima turn up
  function automatic logic [WORD_W-1:0] random_word();
    case ($urandom_range(0, 5))
      0, 1:    return $urandom;
      2:       return WORD_W'($urandom_range(0, 16)) - WORD_W'(8);
      3:       return 32'h8000_0000 + WORD_W'($urandom_range(0, 3));
      4:       return 32'h7FFF_FFFF - WORD_W'($urandom_range(0, 3));
      default: return {8'($urandom_range(0, 255)), 24'h0};
    endcase
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (steady_run || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic issue_request(input logic [1:0] op, input logic [WORD_W-1:0] word,
                               input bit typed, input outcome_t want);
    outcome_t    predicted;
    int unsigned idle;
    start        <= 1'b1;
    func_i       <= op;
    push_value_i <= word;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    // Request taken at this edge
    predicted = stack_model_step(op, word);
    pending_results.push_back(typed ? want : predicted);
    sent_count++;
    idle = pick_gap();
    if (idle != 0) begin
      start <= 1'b0;
      repeat (idle) @(posedge clk_i);
    end
  endtask

  task automatic send_random(input logic [1:0] op);
    issue_request(op, random_word(), 1'b0, '0);
  endtask

  task automatic wait_for_results();
    start <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  always @(posedge clk_i) begin
    outcome_t want;
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected result: expected none, got value %h status %0d", $time,
                 result_value_o, status_o);
      end else begin
        want = pending_results.pop_front();
        if (result_value_o !== want.value || status_o !== want.status) begin
          fail_count++;
          $display("%0t: result mismatch: expected value %h status %0d, %s %h status %0d",
                   $time, want.value, want.status, "got value", result_value_o, status_o);
        end
      end
    end
  end

  initial begin
    int unsigned n;
    int unsigned r;

    stim_table.push_back('{FUNC_POP,  32'h0000_0000, 1'b1, '{32'h0, ST_EMPTY}});
    stim_table.push_back('{FUNC_MIN,  32'hFFFF_FFFF, 1'b1, '{32'h0, ST_EMPTY}});
    stim_table.push_back('{FUNC_NOP,  32'hFFFF_FFFF, 1'b1, '{32'h0, ST_OK}});
    stim_table.push_back('{FUNC_PUSH, 32'h7FFF_FFFF, 1'b1, '{32'h0, ST_OK}});
    stim_table.push_back('{FUNC_MIN,  32'h0000_0000, 1'b1, '{32'h7FFF_FFFF, ST_OK}});
    stim_table.push_back('{FUNC_PUSH, 32'h8000_0000, 1'b1, '{32'h0, ST_OK}});
    stim_table.push_back('{FUNC_MIN,  32'hAAAA_5555, 1'b1, '{32'h8000_0000, ST_OK}});
    stim_table.push_back('{FUNC_PUSH, 32'h0000_0000, 1'b0, '0});
    stim_table.push_back('{FUNC_PUSH, 32'hFFFF_FFFF, 1'b0, '0});
    stim_table.push_back('{FUNC_MIN,  32'h5555_AAAA, 1'b0, '0});
    stim_table.push_back('{FUNC_POP,  32'h0000_0000, 1'b0, '0});
    stim_table.push_back('{FUNC_POP,  32'hFFFF_FFFF, 1'b0, '0});
    stim_table.push_back('{FUNC_POP,  32'h0000_0000, 1'b0, '0});
    stim_table.push_back('{FUNC_MIN,  32'h0000_0000, 1'b0, '0});
    stim_table.push_back('{FUNC_POP,  32'h0000_0000, 1'b0, '0});
    stim_table.push_back('{FUNC_POP,  32'h0000_0000, 1'b1, '{32'h0, ST_EMPTY}});
    stim_table.push_back('{FUNC_NOP,  32'h0000_0000, 1'b1, '{32'h0, ST_OK}});
    stim_table.push_back('{FUNC_PUSH, 32'h0000_0001, 1'b0, '0});
    stim_table.push_back('{FUNC_PUSH, 32'hFFFF_FFFE, 1'b0, '0});
    stim_table.push_back('{FUNC_PUSH, 32'h0000_0005, 1'b0, '0});
    stim_table.push_back('{FUNC_MIN,  32'h0000_0000, 1'b0, '0});
    stim_table.push_back('{FUNC_POP,  32'h0000_0000, 1'b0, '0});
    stim_table.push_back('{FUNC_MIN,  32'h0000_0000, 1'b0, '0});
    stim_table.push_back('{FUNC_POP,  32'h0000_0000, 1'b0, '0});
    stim_table.push_back('{FUNC_POP,  32'h0000_0000, 1'b0, '0});

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (stim_table[i])
      issue_request(stim_table[i].op, stim_table[i].word, stim_table[i].typed,
                    stim_table[i].want);
    // Hold off until the directed part has fully drained
    wait_for_results();

    // Fill to the top first so that overflow is always reached
    while (model_fill < DEPTH) send_random(FUNC_PUSH);
    repeat (3) send_random(FUNC_PUSH);
    send_random(FUNC_MIN);

    while (sent_count < stim_table.size() + RANDOM_REQUESTS) begin
      steady_run = ($urandom_range(0, 4) == 0);
      case ($urandom_range(0, 9))
        0, 1: begin
          while (model_fill < DEPTH) begin
            if ($urandom_range(0, 15) == 0) send_random(FUNC_MIN);
            else send_random(FUNC_PUSH);
          end
          repeat ($urandom_range(1, 3)) send_random(FUNC_PUSH);
          send_random(FUNC_MIN);
        end
        2, 3: begin
          while (model_fill > 0) begin
            if ($urandom_range(0, 3) == 0) send_random(FUNC_MIN);
            else send_random(FUNC_POP);
          end
          repeat ($urandom_range(1, 2))
            send_random($urandom_range(0, 1) ? FUNC_POP : FUNC_MIN);
        end
        default: begin
          n = $urandom_range(5, 40);
          repeat (n) begin
            r = $urandom_range(0, 19);
            if (r < 8) send_random(FUNC_PUSH);
            else if (r < 14) send_random(FUNC_POP);
            else if (r < 19) send_random(FUNC_MIN);
            else send_random(FUNC_NOP);
          end
        end
      endcase
      if ($urandom_range(0, 4) == 0) wait_for_results();
    end

    wait_for_results();
    // Allow for any stray result from a full-depth scan
    repeat (DEPTH + 8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #(20_000_000);
    $display("Some tests failed");
    $finish;
  end

endmodule

@@ files.f @@
+incdir+sv
sv/swmq_pkg.sv
sv/swmq_ram.sv
sv/swmq_ctrl.sv
sv/swmq_dp.sv
sv/stack_with_min_query.sv
dv/tb_stack_with_min_query.sv
